>>> src/sgcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scatter-gather copy planner package
// Item types, input kind codes and register indexes shared by the planner.
// ----------------------------------------------------------------------------
package sgcp_pkg;

   localparam int unsigned ADDR_W  = 48;
   localparam int unsigned LEN_W   = 24;
   localparam int unsigned COUNT_W = 31;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CSR_IDX_W = 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_SRC_SEG = 3'd0,
      KIND_DST_SEG = 3'd1,
      KIND_SRC_END = 3'd2,
      KIND_DST_END = 3'd3,
      KIND_START   = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SKIP_BYTES = 1'd0,
      CSR_BYTE_COUNT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] seg_addr;
      logic [LEN_W-1:0]  seg_len;
   } req_type;

   typedef struct packed {
      logic               copy_valid;
      logic [ADDR_W-1:0]  copy_src_addr;
      logic [ADDR_W-1:0]  copy_dst_addr;
      logic [LEN_W-1:0]   copy_size;
      logic               need_src;
      logic               need_dst;
      logic               done_res;
      logic [COUNT_W-1:0] bytes_copied;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] skip_bytes;
      logic [COUNT_W-1:0] byte_count;
   } cfg_type;

endpackage
`default_nettype wire

>>> src/sgcp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scatter-gather copy planner core
// Holds the segment and transfer state and computes the result of one item.
// ----------------------------------------------------------------------------
module sgcp_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire sgcp_pkg::req_type item,
   input  wire sgcp_pkg::cfg_type cfg,
   output sgcp_pkg::rsp_type     result
);
   import sgcp_pkg::*;

   logic [ADDR_W-1:0]  src_cursor_ff, src_cursor_in;
   logic [LEN_W-1:0]   src_left_ff, src_left_in;
   logic               src_held_ff, src_held_in;
   logic [ADDR_W-1:0]  dst_cursor_ff, dst_cursor_in;
   logic [LEN_W-1:0]   dst_left_ff, dst_left_in;
   logic               dst_held_ff, dst_held_in;
   logic [COUNT_W-1:0] remaining_ff, remaining_in;
   logic [COUNT_W-1:0] skip_left_ff, skip_left_in;
   logic [COUNT_W-1:0] issued_ff, issued_in;
   logic               finished_ff, finished_in;

   logic               err;
   logic               cv;
   logic [LEN_W-1:0]   seg_min;
   logic [LEN_W-1:0]   csize;
   logic [ADDR_W-1:0]  csrc;
   logic [ADDR_W-1:0]  cdst;

   always_comb begin
      src_cursor_in = src_cursor_ff;
      src_left_in   = src_left_ff;
      src_held_in   = src_held_ff;
      dst_cursor_in = dst_cursor_ff;
      dst_left_in   = dst_left_ff;
      dst_held_in   = dst_held_ff;
      remaining_in  = remaining_ff;
      skip_left_in  = skip_left_ff;
      issued_in     = issued_ff;
      finished_in   = finished_ff;
      err           = 1'b0;
      cv            = 1'b0;
      seg_min       = '0;
      csize         = '0;
      csrc          = '0;
      cdst          = '0;

      unique case (item.kind)
         KIND_START: begin
            src_held_in   = 1'b0;
            dst_held_in   = 1'b0;
            src_cursor_in = '0;
            src_left_in   = '0;
            dst_cursor_in = '0;
            dst_left_in   = '0;
            remaining_in  = cfg.byte_count;
            skip_left_in  = cfg.skip_bytes;
            issued_in     = '0;
            finished_in   = (cfg.byte_count == '0);
         end
         KIND_SRC_SEG: begin
            if (finished_ff || src_held_ff) begin
               err = 1'b1;
            end else if (skip_left_ff >= {{(COUNT_W-LEN_W){1'b0}}, item.seg_len}) begin
               skip_left_in = skip_left_ff - {{(COUNT_W-LEN_W){1'b0}}, item.seg_len};
            end else begin
               src_cursor_in = item.seg_addr + {{(ADDR_W-COUNT_W){1'b0}}, skip_left_ff};
               src_left_in   = item.seg_len - skip_left_ff[LEN_W-1:0];
               skip_left_in  = '0;
               src_held_in   = 1'b1;
            end
         end
         KIND_DST_SEG: begin
            if (finished_ff || dst_held_ff) begin
               err = 1'b1;
            end else if (item.seg_len != '0) begin
               dst_cursor_in = item.seg_addr;
               dst_left_in   = item.seg_len;
               dst_held_in   = 1'b1;
            end
         end
         KIND_SRC_END: begin
            if (finished_ff || src_held_ff) begin
               err = 1'b1;
            end else begin
               finished_in = 1'b1;
               src_held_in = 1'b0;
               dst_held_in = 1'b0;
            end
         end
         KIND_DST_END: begin
            if (finished_ff || dst_held_ff) begin
               err = 1'b1;
            end else begin
               finished_in = 1'b1;
               src_held_in = 1'b0;
               dst_held_in = 1'b0;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase

      if (!err && !finished_in && src_held_in && dst_held_in) begin
         cv      = 1'b1;
         seg_min = (src_left_in < dst_left_in) ? src_left_in : dst_left_in;
         csize   = (remaining_in < {{(COUNT_W-LEN_W){1'b0}}, seg_min}) ?
                   remaining_in[LEN_W-1:0] : seg_min;
         csrc    = src_cursor_in;
         cdst    = dst_cursor_in;
         src_cursor_in = src_cursor_in + {{(ADDR_W-LEN_W){1'b0}}, csize};
         dst_cursor_in = dst_cursor_in + {{(ADDR_W-LEN_W){1'b0}}, csize};
         src_left_in   = src_left_in - csize;
         dst_left_in   = dst_left_in - csize;
         if (src_left_in == '0) begin
            src_held_in = 1'b0;
         end
         if (dst_left_in == '0) begin
            dst_held_in = 1'b0;
         end
         remaining_in = remaining_in - {{(COUNT_W-LEN_W){1'b0}}, csize};
         issued_in    = issued_ff + {{(COUNT_W-LEN_W){1'b0}}, csize};
         if (remaining_in == '0) begin
            finished_in = 1'b1;
            src_held_in = 1'b0;
            dst_held_in = 1'b0;
         end
      end
   end

   always_comb begin
      result.copy_valid    = cv;
      result.copy_src_addr = csrc;
      result.copy_dst_addr = cdst;
      result.copy_size     = csize;
      result.need_src      = !finished_in && !src_held_in;
      result.need_dst      = !finished_in && !dst_held_in;
      result.done_res      = finished_in;
      result.bytes_copied  = issued_in;
      result.error         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cursor_ff <= '0;
         src_left_ff   <= '0;
         src_held_ff   <= 1'b0;
         dst_cursor_ff <= '0;
         dst_left_ff   <= '0;
         dst_held_ff   <= 1'b0;
         remaining_ff  <= '0;
         skip_left_ff  <= '0;
         issued_ff     <= '0;
         finished_ff   <= 1'b1;
      end else if (fire) begin
         src_cursor_ff <= src_cursor_in;
         src_left_ff   <= src_left_in;
         src_held_ff   <= src_held_in;
         dst_cursor_ff <= dst_cursor_in;
         dst_left_ff   <= dst_left_in;
         dst_held_ff   <= dst_held_in;
         remaining_ff  <= remaining_in;
         skip_left_ff  <= skip_left_in;
         issued_ff     <= issued_in;
         finished_ff   <= finished_in;
      end
   end

endmodule
`default_nettype wire

>>> src/scatter_gather_copy_planner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scatter-gather copy planner
// Pairs source and destination segment descriptors into copy commands.
//
//   Port group   Direction   Handshake           Carries
//   req_*        in          req_valid/stall     one descriptor or control item
//   rsp_*        out         rsp_valid/stall     one result per item
//   csr_*        in          csr_we              skip_bytes, byte_count
//
// Each item passes an input register and then the result register before its
// result appears on rsp. One item per cycle is sustained while rsp is not
// stalled; the per-item state update is combinational compare, subtract and
// add logic. Reset is synchronous and leaves the planner finished until a
// start item. A stalled result holds the input register, which then stalls
// req.
// ----------------------------------------------------------------------------
module scatter_gather_copy_planner_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sgcp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sgcp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [sgcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sgcp_pkg::COUNT_W-1:0]        csr_wdata
);
   import sgcp_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg_ff, cfg_in;
   rsp_type step_result;
   logic    out_ready;
   logic    advance;
   logic    req_take;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SKIP_BYTES: cfg_in.skip_bytes = csr_wdata;
            CSR_BYTE_COUNT: cfg_in.byte_count = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   sgcp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

`ifndef SYNTHESIS
   a_copy_not_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.copy_valid |-> !rsp_data.error)
      else $error("copy command issued on an unexpected item");

   a_copy_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.copy_valid |-> rsp_data.copy_size != '0)
      else $error("copy command of zero bytes");

   a_done_no_need: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.need_src && !rsp_data.need_dst)
      else $error("finished transfer still asks for segments");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled without a full pipeline");
`endif

endmodule
`default_nettype wire
